[src/qte_pkg.sv]
// Package for the quaternion to Euler angle converter.
// Holds widths, the CORDIC arctangent table and the transaction structs.
// No dependencies.
package qte_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int QW            = 16;
    localparam int PW            = 2 * QW;
    localparam int CW            = 36;
    localparam int ZW            = 32;
    localparam int SQRT_BITS     = 31;
    localparam int RAD_W         = 63;
    localparam int FRAC_BITS     = 30;
    localparam int PIPE_DEPTH    = 2 + SQRT_BITS + CORDIC_STAGES + 1;

    localparam logic [ZW-1:0] ANGLE_MASK = (ANGLE_BITS == 32) ? '1 :
        ~((ZW'(1) << (32 - ANGLE_BITS)) - ZW'(1));
    localparam logic [ZW-1:0] HALF_TURN  = 32'h8000_0000;
    localparam logic signed [CW-1:0] ONE_Q30 = CW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [17:0] PITCH_MAX = 18'sd16384;
    localparam logic signed [17:0] PITCH_MIN = -18'sd16384;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
    localparam logic [ZW-1:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } t_euler;

endpackage

[src/qte_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(y, x) as a 32-bit turn count.
// Depends on qte_pkg for widths and the arctangent table.
module qte_cordic import qte_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_x,
    output logic [ZW-1:0]        o_angle
);

    logic signed [CW-1:0] r_x    [CORDIC_STAGES+1];
    logic signed [CW-1:0] r_y    [CORDIC_STAGES+1];
    logic [ZW-1:0]        r_z    [CORDIC_STAGES+1];
    logic                 r_zero [CORDIC_STAGES+1];

    // Pre-rotation: fold the left half plane onto the right by half a turn.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[CW-1]) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= HALF_TURN & ANGLE_MASK;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage, driving y towards zero.
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        localparam logic [ZW-1:0] STEP = ATAN_TURNS[g] & ANGLE_MASK;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                if (!r_y[g][CW-1]) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + STEP;
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - STEP;
                end
            end
        end
    end

    // A zero vector has no direction and reads as angle zero.
    assign o_angle = r_zero[CORDIC_STAGES] ? '0 : r_z[CORDIC_STAGES];

endmodule

[src/quaternion_to_euler.sv]
// Quaternion to roll, pitch and yaw converter, top level.
// Throughput: one transaction per cycle unless the output stalls; the 31-stage
// square root and the 17-stage pitch CORDIC set the depth.
// A stalled output freezes the whole pipeline; synchronous reset empties it.
// Depends on qte_pkg and qte_cordic.
module quaternion_to_euler import qte_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_quat  i_quat,
    output logic   o_valid,
    input  logic   i_stall,
    output t_euler o_euler
);

    logic                  en;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  r_out_valid;
    t_euler                r_out;

    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_xz;
    logic signed [CW-1:0] r_sr, r_cr, r_sy, r_cy;
    logic signed [CW-1:0] n_t, t_clamp;
    logic [31:0]          r_ta [2];

    logic [RAD_W-1:0]     r_rem  [2][SQRT_BITS];
    logic [SQRT_BITS-1:0] r_root [2][SQRT_BITS];

    logic [ZW-1:0]        roll_z, yaw_z, pitch_z;
    logic [ZW-1:0]        r_roll_dly [SQRT_BITS];
    logic [ZW-1:0]        r_yaw_dly  [SQRT_BITS];

    logic signed [33:0]   pitch_p;
    logic signed [17:0]   pitch_r;
    logic [ZW-1:0]        roll_rnd, yaw_rnd;

    // The whole pipeline advances unless a finished result is held up.
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;
    assign o_valid = r_out_valid;
    assign o_euler = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[PIPE_DEPTH-2:0], i_valid};
            r_out_valid <= r_vld[PIPE_DEPTH-1];
        end
    end

    // Stage one: the nine component products, exact in Q2.30.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= i_quat.quat_w * i_quat.quat_x;
            r_yz <= i_quat.quat_y * i_quat.quat_z;
            r_xx <= i_quat.quat_x * i_quat.quat_x;
            r_yy <= i_quat.quat_y * i_quat.quat_y;
            r_wz <= i_quat.quat_w * i_quat.quat_z;
            r_xy <= i_quat.quat_x * i_quat.quat_y;
            r_zz <= i_quat.quat_z * i_quat.quat_z;
            r_wy <= i_quat.quat_w * i_quat.quat_y;
            r_xz <= i_quat.quat_x * i_quat.quat_z;
        end
    end

    // Stage two: atan2 operands and the clamped pitch term.
    always_comb begin
        n_t = (CW'(r_wy) - CW'(r_xz)) <<< 1;
        if (n_t > ONE_Q30) begin
            t_clamp = ONE_Q30;
        end else if (n_t < -ONE_Q30) begin
            t_clamp = -ONE_Q30;
        end else begin
            t_clamp = n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr    <= (CW'(r_wx) + CW'(r_yz)) <<< 1;
            r_cr    <= ONE_Q30 - ((CW'(r_xx) + CW'(r_yy)) <<< 1);
            r_sy    <= (CW'(r_wz) + CW'(r_xy)) <<< 1;
            r_cy    <= ONE_Q30 - ((CW'(r_yy) + CW'(r_zz)) <<< 1);
            r_ta[0] <= 32'(ONE_Q30 + t_clamp);
            r_ta[1] <= 32'(ONE_Q30 - t_clamp);
        end
    end

    // Integer square roots giving sqrt(1+t) and sqrt(1-t), one root bit a stage.
    for (genvar l = 0; l < 2; l++) begin : g_lane
        for (genvar j = 0; j < SQRT_BITS; j++) begin : g_bit
            localparam int K = SQRT_BITS - 1 - j;
            logic [RAD_W-1:0]     prev_rem;
            logic [SQRT_BITS-1:0] prev_root;
            logic [RAD_W-1:0]     trial;
            if (j == 0) begin : g_first
                assign prev_rem  = RAD_W'({r_ta[l], {FRAC_BITS{1'b0}}});
                assign prev_root = '0;
            end else begin : g_next
                assign prev_rem  = r_rem[l][j-1];
                assign prev_root = r_root[l][j-1];
            end
            assign trial = (RAD_W'(prev_root) << (K + 1)) + (RAD_W'(1) << (2 * K));
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (trial <= prev_rem) begin
                        r_rem[l][j]  <= prev_rem - trial;
                        r_root[l][j] <= prev_root | (SQRT_BITS'(1) << K);
                    end else begin
                        r_rem[l][j]  <= prev_rem;
                        r_root[l][j] <= prev_root;
                    end
                end
            end
        end
    end

    // Roll and yaw arctangents run alongside the square roots.
    qte_cordic u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_sr),
        .i_x     (r_cr),
        .o_angle (roll_z)
    );

    qte_cordic u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_sy),
        .i_x     (r_cy),
        .o_angle (yaw_z)
    );

    // Pitch angle is 2 * atan2(sqrt(1+t), sqrt(1-t)) - pi/2.
    qte_cordic u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     ($signed({{(CW-SQRT_BITS){1'b0}}, r_root[0][SQRT_BITS-1]})),
        .i_x     ($signed({{(CW-SQRT_BITS){1'b0}}, r_root[1][SQRT_BITS-1]})),
        .o_angle (pitch_z)
    );

    // Roll and yaw wait for the pitch path to catch up.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll_dly[0] <= roll_z;
            r_yaw_dly[0]  <= yaw_z;
            for (int k = 1; k < SQRT_BITS; k++) begin
                r_roll_dly[k] <= r_roll_dly[k-1];
                r_yaw_dly[k]  <= r_yaw_dly[k-1];
            end
        end
    end

    // Output stage: round to 16 bits and clamp pitch to a quarter turn.
    always_comb begin
        pitch_p  = (34'(signed'(pitch_z)) <<< 1) - 34'(ONE_Q30);
        pitch_r  = 18'((pitch_p + 34'sd32768) >>> 16);
        roll_rnd = r_roll_dly[SQRT_BITS-1] + 32'h8000;
        yaw_rnd  = r_yaw_dly[SQRT_BITS-1] + 32'h8000;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.roll_angle <= roll_rnd[31:16];
            r_out.yaw_angle  <= yaw_rnd[31:16];
            if (pitch_r > PITCH_MAX) begin
                r_out.pitch_angle <= 16'(PITCH_MAX);
            end else if (pitch_r < PITCH_MIN) begin
                r_out.pitch_angle <= 16'(PITCH_MIN);
            end else begin
                r_out.pitch_angle <= 16'(pitch_r);
            end
        end
    end

    // The pitch result never leaves its quarter turn.
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_euler.pitch_angle <= 16'sd16384 &&
                     o_euler.pitch_angle >= -16'sd16384))
        else $error("pitch angle out of range");

    // The input side is held off only by a waiting result.
    a_stall_cause: assert property (@(posedge i_clk)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    // A held result keeps its valid until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_euler)))
        else $error("stalled result changed");

endmodule
